// ===== rtl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg: shared types and constants
// Opcodes, widths and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int NODES    = 1024;
    localparam int MAX_LINE = 65536;
    localparam int NW       = $clog2(NODES);
    localparam int CW       = NW + 1;
    localparam int LW       = $clog2(MAX_LINE) + 1;
    localparam int WLW      = CW;

    localparam logic [2:0] OP_PAT   = 3'd0;
    localparam logic [2:0] OP_ENDP  = 3'd1;
    localparam logic [2:0] OP_BUILD = 3'd2;
    localparam logic [2:0] OP_TEXT  = 3'd3;
    localparam logic [2:0] OP_EOL   = 3'd4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] symbol;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic        found;
        logic [15:0] first_start;
        logic        status;
    } t_out;

    typedef enum logic [3:0] {
        C_NONE   = 4'b0000,
        C_CLEAR  = 4'b0001,
        C_START  = 4'b0010,
        C_STEP   = 4'b0100,
        C_FINISH = 4'b1000
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [2:0] opcode;
        logic [7:0] symbol;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic done;
        t_out result;
        logic has_result;
    } t_stat;

endpackage

// ===== rtl/mpsm_if.sv =====
// ----------------------------------------------------------------------------
// mpsm_if: valid/ready stream channel
// Carries one payload with source and sink views.
// ----------------------------------------------------------------------------
interface mpsm_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mpsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpsm_ctrl: sequencing controller
// Clears tables after reset, takes one item, steps the datapath, posts result.
// ----------------------------------------------------------------------------
module mpsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mpsm_pkg::t_in   i_in_data,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output mpsm_pkg::t_out  o_out_data,
    input  logic            i_out_ready,
    output mpsm_pkg::t_cmd  o_cmd,
    input  mpsm_pkg::t_stat i_stat
);
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RUN   = 4'b0100,
        S_POST  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov, n_ov;
    mpsm_pkg::t_out r_od, n_od;
    mpsm_pkg::t_in  r_item, n_item;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !i_out_ready;
        n_od    = r_od;
        n_item  = r_item;
        o_cmd.op     = mpsm_pkg::C_NONE;
        o_cmd.opcode = r_item.opcode;
        o_cmd.symbol = r_item.symbol;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = mpsm_pkg::C_CLEAR;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item       = i_in_data;
                    o_cmd.op     = mpsm_pkg::C_START;
                    o_cmd.opcode = i_in_data.opcode;
                    o_cmd.symbol = i_in_data.symbol;
                    n_state      = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.op = mpsm_pkg::C_STEP;
                if (i_stat.done) begin
                    if (i_stat.has_result) n_state = S_POST;
                    else n_state = S_IDLE;
                end
            end
            S_POST: begin
                // wait for the output register to drain
                if (!r_ov || i_out_ready) begin
                    o_cmd.op = mpsm_pkg::C_FINISH;
                    n_ov     = 1'b1;
                    n_od     = i_stat.result;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_od   <= n_od;
        r_item <= n_item;
    end
endmodule

// ===== rtl/mpsm_dp.sv =====
// ----------------------------------------------------------------------------
// mpsm_dp: trie, link and scan datapath
// Child, failure, word-length and queue memories with a micro-step sequencer.
// ----------------------------------------------------------------------------
module mpsm_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mpsm_pkg::t_cmd  i_cmd,
    output mpsm_pkg::t_stat o_stat
);
    localparam int NW  = mpsm_pkg::NW;
    localparam int CW  = mpsm_pkg::CW;
    localparam int LW  = mpsm_pkg::LW;
    localparam int AW  = NW + 8;
    localparam int WLW = mpsm_pkg::WLW;
    localparam int ND  = mpsm_pkg::NODES;

    // memories: child table, failure links, word length (valid+len), queue
    logic [NW-1:0]  m_child [2**AW];
    logic [NW-1:0]  m_fail  [ND];
    logic [WLW:0]   m_wl    [ND];
    logic [NW-1:0]  m_q     [ND];

    // micro states
    typedef enum logic [14:0] {
        U_IDLE  = 15'h0001,
        U_PRD   = 15'h0002,
        U_PWR   = 15'h0004,
        U_TRD   = 15'h0008,
        U_TCHK  = 15'h0010,
        U_TWL   = 15'h0020,
        U_TFIN  = 15'h0040,
        U_BRT   = 15'h0080,
        U_BHD   = 15'h0100,
        U_BKID  = 15'h0200,
        U_BFW   = 15'h0400,
        U_BFK   = 15'h0800,
        U_BSET  = 15'h1000,
        U_BWL   = 15'h2000,
        U_DONE  = 15'h4000
    } t_u;
    t_u r_u;

    // child read port
    logic [AW-1:0] ca;
    logic [NW-1:0] r_cd;
    // fail / wl / queue read ports
    logic [NW-1:0] fa, wa, qa;
    logic [NW-1:0] r_fd, r_qd;
    logic [WLW:0]  r_wd;
    logic          cwe, fwe, wwe, qwe;
    logic [AW-1:0] cwa;
    logic [NW-1:0] cwd, fwa, fwd, wwa, qwa, qwd;
    logic [WLW:0]  wwd;

    always_ff @(posedge i_clk) begin
        if (cwe) m_child[cwa] <= cwd;
        r_cd <= m_child[ca];
    end
    always_ff @(posedge i_clk) begin
        if (fwe) m_fail[fwa] <= fwd;
        r_fd <= m_fail[fa];
    end
    always_ff @(posedge i_clk) begin
        if (wwe) m_wl[wwa] <= wwd;
        r_wd <= m_wl[wa];
    end
    always_ff @(posedge i_clk) begin
        if (qwe) m_q[qwa] <= qwd;
        r_qd <= m_q[qa];
    end

    // architectural state
    logic [CW-1:0] r_used;
    logic [NW-1:0] r_ins;
    logic [CW-1:0] r_ilen;
    logic [NW-1:0] r_scan;
    logic [LW-1:0] r_pos;
    logic [LW-1:0] r_best;
    logic          r_bval, r_full;
    logic [AW:0]   r_clr;
    // work registers
    logic [7:0]    r_sym, r_a;
    logic [NW-1:0] r_s, r_r, r_u_node, r_v;
    logic [CW-1:0] r_steps, r_head, r_tail;
    logic          r_rootphase;
    logic          r_res;
    logic [2:0]    r_ptype;
    logic [WLW:0]  r_fwl;

    wire clearing = (i_cmd.op == mpsm_pkg::C_CLEAR);
    wire clr_end  = r_clr[AW];
    wire is_eol   = (r_ptype == mpsm_pkg::OP_EOL);
    assign o_stat.clear_done = clr_end;
    assign o_stat.done       = (r_u == U_DONE);
    assign o_stat.has_result = r_res;
    assign o_stat.result.kind        = is_eol;
    assign o_stat.result.found       = is_eol && r_bval;
    assign o_stat.result.first_start = (is_eol && r_bval) ? r_best[15:0] : 16'd0;
    assign o_stat.result.status      = r_full;

    wire          brk = (r_sym == 8'd0) || (r_sym == 8'd10) || (r_sym == 8'd13);
    wire [LW:0]   p1  = {1'b0, r_pos} + 1'b1;
    wire [LW:0]   tlen  = {{(LW-WLW+1){1'b0}}, r_wd[WLW-1:0]};
    wire [LW-1:0] tstart = (p1 >= tlen) ? LW'(p1 - tlen) : '0;

    // combinational port selection
    always_comb begin
        ca  = {r_s, r_sym};
        fa  = r_s;
        wa  = r_s;
        qa  = r_head[NW-1:0];
        cwe = 1'b0; cwa = r_clr[AW-1:0]; cwd = '0;
        fwe = 1'b0; fwa = r_u_node; fwd = '0;
        wwe = 1'b0; wwa = r_clr[NW-1:0]; wwd = '0;
        qwe = 1'b0; qwa = r_tail[NW-1:0]; qwd = r_u_node;
        if (clearing && !clr_end) begin
            cwe = 1'b1;
            wwe = (r_clr[AW-1:NW] == '0);
        end
        case (r_u)
            U_PRD: begin
                ca = {r_ins, r_sym};
                if (r_ptype == mpsm_pkg::OP_ENDP && !r_full) begin
                    wwe = 1'b1; wwa = r_ins; wwd = {1'b1, r_ilen};
                end
            end
            U_PWR: begin
                if (r_cd == '0 && r_used < CW'(ND)) begin
                    cwe = 1'b1; cwa = {r_ins, r_sym}; cwd = r_used[NW-1:0];
                    wwe = 1'b1; wwa = r_used[NW-1:0]; wwd = '0;
                end
            end
            U_BRT: begin
                ca = {{NW{1'b0}}, r_a};
                // act on the root child read in the previous cycle
                if (r_rootphase && r_cd != '0) begin
                    fwe = 1'b1; fwa = r_cd; fwd = '0;
                    qwe = r_tail < CW'(ND); qwd = r_cd;
                end
            end
            U_BKID: begin
                ca = {r_r, r_a};
                fa = r_r;
                if (r_rootphase && r_cd != '0) begin
                    qwe = r_tail < CW'(ND); qwd = r_cd;
                end
            end
            U_BFW: begin
                ca = {r_v, r_a};
                fa = r_v;
            end
            U_BFK:  ca = {r_v, r_a};
            U_BSET: begin
                ca  = {r_v, r_a};
                wa  = r_cd;
                fwe = 1'b1; fwa = r_u_node; fwd = r_cd;
            end
            U_BWL: begin
                wa = r_u_node;
                if (r_rootphase && r_fwl[WLW] &&
                    (!r_wd[WLW] || r_fwl[WLW-1:0] > r_wd[WLW-1:0])) begin
                    wwe = 1'b1; wwa = r_u_node; wwd = r_fwl;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u    <= U_IDLE;
            r_used <= CW'(1);
            r_ins  <= '0;
            r_ilen <= '0;
            r_scan <= '0;
            r_pos  <= '0;
            r_bval <= 1'b0;
            r_best <= '0;
            r_full <= 1'b0;
            r_clr  <= '0;
            r_res  <= 1'b0;
        end else begin
            if (clearing && !clr_end) r_clr <= r_clr + 1'b1;
            case (r_u)
                U_IDLE: begin
                    if (i_cmd.op == mpsm_pkg::C_START) begin
                        r_res   <= (i_cmd.opcode == mpsm_pkg::OP_BUILD) ||
                                   (i_cmd.opcode == mpsm_pkg::OP_EOL);
                        r_sym   <= i_cmd.symbol;
                        r_ptype <= i_cmd.opcode;
                        case (i_cmd.opcode)
                            mpsm_pkg::OP_PAT:  r_u <= U_PRD;
                            mpsm_pkg::OP_ENDP: r_u <= U_PRD;
                            mpsm_pkg::OP_BUILD: begin
                                r_a <= '0; r_head <= '0; r_tail <= '0;
                                r_rootphase <= 1'b0;
                                r_u <= U_BRT;
                            end
                            mpsm_pkg::OP_TEXT: begin
                                if (r_pos >= LW'(mpsm_pkg::MAX_LINE)) r_u <= U_DONE;
                                else begin
                                    r_s <= r_scan; r_steps <= '0; r_u <= U_TRD;
                                end
                            end
                            mpsm_pkg::OP_EOL: r_u <= U_DONE;
                            default: r_u <= U_DONE;
                        endcase
                    end
                end
                U_PRD: begin
                    if (r_ptype == mpsm_pkg::OP_ENDP) begin
                        r_ins <= '0; r_ilen <= '0; r_u <= U_DONE;
                    end else r_u <= U_PWR;
                end
                U_PWR: begin
                    if (r_cd == '0) begin
                        if (r_used < CW'(ND)) begin
                            r_ins  <= r_used[NW-1:0];
                            r_used <= r_used + 1'b1;
                        end else r_full <= 1'b1;
                    end else r_ins <= r_cd;
                    if (r_ilen < CW'(ND)) r_ilen <= r_ilen + 1'b1;
                    r_u <= U_DONE;
                end
                U_TRD: begin
                    if (brk) begin
                        r_scan <= '0; r_pos <= p1[LW-1:0]; r_u <= U_DONE;
                    end else r_u <= U_TCHK;
                end
                U_TCHK: begin
                    if (r_cd != '0) begin
                        r_s <= r_cd; r_u <= U_TWL;
                    end else if (r_s == '0 || r_steps >= CW'(ND)) begin
                        r_s <= '0; r_u <= U_TWL;
                    end else begin
                        r_s <= r_fd; r_steps <= r_steps + 1'b1; r_u <= U_TRD;
                    end
                end
                U_TWL: begin
                    r_u <= U_TFIN;
                end
                U_TFIN: begin
                    r_scan <= r_s;
                    r_pos  <= p1[LW-1:0];
                    if (r_wd[WLW]) begin
                        if (!r_bval || tstart < r_best) begin
                            r_best <= tstart; r_bval <= 1'b1;
                        end
                    end
                    r_u <= U_DONE;
                end
                // root children: each byte is read, then acted on
                U_BRT: begin
                    if (r_rootphase) begin
                        r_rootphase <= 1'b0;
                        if (r_cd != '0 && r_tail < CW'(ND)) r_tail <= r_tail + 1'b1;
                        if (r_a == 8'hFF) r_u <= U_BHD;
                        r_a <= r_a + 1'b1;
                    end else r_rootphase <= 1'b1;
                end
                U_BHD: begin
                    if (r_head >= r_tail) r_u <= U_DONE;
                    else if (r_rootphase) begin
                        r_r <= r_qd; r_a <= '0; r_head <= r_head + 1'b1;
                        r_rootphase <= 1'b0; r_u <= U_BKID;
                    end else r_rootphase <= 1'b1;
                end
                U_BKID: begin
                    if (!r_rootphase) r_rootphase <= 1'b1;
                    else begin
                        r_rootphase <= 1'b0;
                        if (r_cd == '0) begin
                            if (r_a == 8'hFF) r_u <= U_BHD;
                            r_a <= r_a + 1'b1;
                        end else begin
                            r_u_node <= r_cd;
                            if (r_tail < CW'(ND)) r_tail <= r_tail + 1'b1;
                            // start the walk at the failure link of the queue node
                            r_v <= r_fd; r_steps <= '0; r_u <= U_BFW;
                        end
                    end
                end
                U_BFW: begin
                    if (!r_rootphase) r_rootphase <= 1'b1;
                    else begin
                        r_rootphase <= 1'b0;
                        if (r_v != '0 && r_cd == '0 && r_steps < CW'(ND)) begin
                            r_v <= r_fd; r_steps <= r_steps + 1'b1;
                        end else begin
                            if (r_steps >= CW'(ND)) r_v <= '0;
                            r_u <= U_BFK;
                        end
                    end
                end
                U_BFK: begin
                    if (!r_rootphase) r_rootphase <= 1'b1;
                    else begin r_rootphase <= 1'b0; r_u <= U_BSET; end
                end
                U_BSET: begin
                    if (!r_rootphase) r_rootphase <= 1'b1;
                    else begin
                        r_rootphase <= 1'b0; r_fwl <= r_wd; r_u <= U_BWL;
                    end
                end
                U_BWL: begin
                    if (!r_rootphase) r_rootphase <= 1'b1;
                    else begin
                        r_rootphase <= 1'b0;
                        if (r_a == 8'hFF) r_u <= U_BHD;
                        else r_u <= U_BKID;
                        r_a <= r_a + 1'b1;
                    end
                end
                U_DONE: begin
                    if (!r_res) r_u <= U_IDLE;
                    else if (i_cmd.op == mpsm_pkg::C_FINISH) begin
                        if (is_eol) begin
                            r_scan <= '0; r_pos <= '0; r_best <= '0; r_bval <= 1'b0;
                        end
                        r_res <= 1'b0;
                        r_u <= U_IDLE;
                    end
                end
                default: r_u <= U_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/multi_pattern_string_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher: Aho-Corasick pattern engine
// Builds a trie from pattern bytes, links it, then scans text lines.
// ----------------------------------------------------------------------------
// Input channel i_in carries opcode and symbol; output channel o_out carries
// kind, found, first_start and status. One item is worked on at a time.
// After reset the child table and word lengths are cleared, one entry per
// cycle over all 262144 child entries; no item is taken during that pass.
// Pattern byte: child memory read, then a write if the child is new.
// End pattern: word-length write. Text byte: child and failure-link read,
// repeated for each failure link followed, then a word-length read; a line
// break byte resets the scan state. Build: each root child slot is read,
// then acted on; then each queued node has its child slots read, and for
// each child found the failure link is walked and set, the word length merged.
// End line: the result goes to the output register and the line is reset.
// A result waits in the output register while the receiver stalls; the next
// item is not taken until it has been posted.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher (
    input  logic i_clk,
    input  logic i_rst_n,
    mpsm_if.sink   i_in,
    mpsm_if.source o_out
);
    mpsm_pkg::t_cmd  w_cmd;
    mpsm_pkg::t_stat w_stat;

    mpsm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .i_in_data(i_in.data), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .o_out_data(o_out.data), .i_out_ready(o_out.ready),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    mpsm_dp u_dp (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat));

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> w_cmd.op != mpsm_pkg::C_STEP)
        else $error("accepting while busy");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.data.kind |-> !o_out.data.found)
        else $error("build result reports a match");
endmodule
